### hw/rtl/sbsh_pkg.sv
// shared types, round constants and initial hash values for the sha-256 byte hasher
package sbsh_pkg;

    typedef logic [7:0][31:0] words_t;

    typedef struct packed {
        logic shift_byte;
        logic shift_word;
    } buf_ctrl_t;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_POS     = 6'd63;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/sbsh_round.sv
// one sha-256 compression round on the working variables a..h
module sbsh_round import sbsh_pkg::*; (
    input  words_t      wv_in,
    input  logic [31:0] k_in,
    input  logic [31:0] w_in,
    output words_t      wv_out
);

    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

    always_comb begin
        big_s1 = rotr(wv_in[4], 6) ^ rotr(wv_in[4], 11) ^ rotr(wv_in[4], 25);
        ch     = (wv_in[4] & wv_in[5]) ^ (~wv_in[4] & wv_in[6]);
        big_s0 = rotr(wv_in[0], 2) ^ rotr(wv_in[0], 13) ^ rotr(wv_in[0], 22);
        maj    = (wv_in[0] & wv_in[1]) ^ (wv_in[0] & wv_in[2]) ^ (wv_in[1] & wv_in[2]);
        t1     = wv_in[7] + big_s1 + ch + k_in + w_in;
        t2     = big_s0 + maj;
        wv_out[7] = wv_in[6];
        wv_out[6] = wv_in[5];
        wv_out[5] = wv_in[4];
        wv_out[4] = wv_in[3] + t1;
        wv_out[3] = wv_in[2];
        wv_out[2] = wv_in[1];
        wv_out[1] = wv_in[0];
        wv_out[0] = t1 + t2;
    end

endmodule

### hw/rtl/sbsh_msg_buf.sv
// 64-byte block buffer that doubles as the rolling message schedule
module sbsh_msg_buf import sbsh_pkg::*; (
    input  logic        aclk,
    input  buf_ctrl_t   ctrl,
    input  logic [7:0]  byte_in,
    output logic [31:0] w_out
);

    // word 15 (top) is the oldest: w[t], word 15-j holds w[t+j]
    logic [15:0][31:0] buf_reg, buf_next;
    logic [31:0]       sig0, sig1, w_new;

    always_comb begin
        sig1  = rotr(buf_reg[1], 17) ^ rotr(buf_reg[1], 19) ^ (buf_reg[1] >> 10);
        sig0  = rotr(buf_reg[14], 7) ^ rotr(buf_reg[14], 18) ^ (buf_reg[14] >> 3);
        w_new = sig1 + buf_reg[6] + sig0 + buf_reg[15];
        buf_next = buf_reg;
        if (ctrl.shift_byte) begin
            buf_next = 512'({buf_reg, byte_in});
        end else if (ctrl.shift_word) begin
            buf_next = {buf_reg[14:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign w_out = buf_reg[15];

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
// top level of the sha-256 byte stream hasher: sequencer, chaining state and output register
//
//  channel | dir | ports                               | contents
//  --------+-----+-------------------------------------+----------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser    | one message byte per word,
//          |     | s_tlast                             | has_byte flag, end of message
//  m_      | out | m_tvalid m_tready m_tdata           | 256-bit digest per message
//
//  byte words are accepted only while idle; the 64th byte of a block starts the rounds and
//  the chaining add, all through the single shared round unit
//  the end of a message shifts in the padding bytes (up to 64 in one block, up to
//  72 over two), compresses each padding block and then loads the digest
//  reset is synchronous; it restores the initial hash values and clears counters
//  a stalled digest holds the block in its final state until m_tready takes it
module sha256_byte_stream_hasher import sbsh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         s_tuser,     // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata      // [63:0] digest_hi, [127:64] digest_midhi,
                                      // [191:128] digest_midlo, [255:192] digest_lo
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;        // bytes held in the current block
    logic [60:0]  len_reg, len_next;          // message length in bytes
    logic [5:0]   round_reg, round_next;
    logic         end_pending_reg, end_pending_next;  // message ended on a full block
    logic         pad_active_reg, pad_active_next;
    logic         pad_first_reg, pad_first_next;      // next pad byte is the 0x80 mark
    logic         len_ok_reg, len_ok_next;            // this block carries the length
    words_t       h_reg, h_next;
    words_t       wv_reg, wv_next;
    words_t       wv_round;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [255:0] m_data_reg, m_data_next;

    buf_ctrl_t    buf_ctrl;
    logic [7:0]   buf_byte;
    logic [31:0]  w_cur;
    logic [63:0]  len_bits;
    logic         s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign len_bits = {len_reg, 3'b000};

    sbsh_msg_buf u_msg_buf (
        .aclk    (aclk),
        .ctrl    (buf_ctrl),
        .byte_in (buf_byte),
        .w_out   (w_cur)
    );

    sbsh_round u_round (
        .wv_in  (wv_reg),
        .k_in   (round_k(round_reg)),
        .w_in   (w_cur),
        .wv_out (wv_round)
    );

    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        len_next         = len_reg;
        round_next       = round_reg;
        end_pending_next = end_pending_reg;
        pad_active_next  = pad_active_reg;
        pad_first_next   = pad_first_reg;
        len_ok_next      = len_ok_reg;
        h_next           = h_reg;
        wv_next          = wv_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_data_next      = m_data_reg;
        buf_ctrl         = '0;
        buf_byte         = s_tdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        buf_ctrl.shift_byte = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 61'd1;
                        if (fill_reg == LAST_POS) begin
                            // block full: compress, then pad if this was the end
                            end_pending_next = s_tlast;
                            wv_next    = h_reg;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end else if (s_tlast) begin
                            pad_active_next = 1'b1;
                            pad_first_next  = 1'b1;
                            len_ok_next     = 1'b0;
                            state_next      = ST_PAD;
                        end
                    end else if (s_tlast) begin
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                        len_ok_next     = 1'b0;
                        state_next      = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                buf_ctrl.shift_word = 1'b1;
                wv_next    = wv_round;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    h_next[i] = h_reg[i] + wv_reg[i];
                end
                if (pad_active_reg) begin
                    if (len_ok_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        // 0x80 landed past the length field: one more block
                        len_ok_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end else if (end_pending_reg) begin
                    end_pending_next = 1'b0;
                    pad_active_next  = 1'b1;
                    pad_first_next   = 1'b1;
                    len_ok_next      = 1'b0;
                    state_next       = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                buf_ctrl.shift_byte = 1'b1;
                if (pad_first_reg) begin
                    buf_byte       = PAD_MARK;
                    pad_first_next = 1'b0;
                    len_ok_next    = (fill_reg < LEN_POS);
                end else if (len_ok_reg && fill_reg >= LEN_POS) begin
                    // big-endian bit length in the last eight bytes
                    buf_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
                end else begin
                    buf_byte = 8'h00;
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS) begin
                    wv_next    = h_reg;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {h_reg[6], h_reg[7], h_reg[4], h_reg[5],
                                     h_reg[2], h_reg[3], h_reg[0], h_reg[1]};
                    for (int i = 0; i < 8; i++) begin
                        h_next[i] = init_h(3'(i));
                    end
                    fill_next       = '0;
                    len_next        = '0;
                    pad_active_next = 1'b0;
                    len_ok_next     = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            len_reg         <= '0;
            round_reg       <= '0;
            end_pending_reg <= 1'b0;
            pad_active_reg  <= 1'b0;
            pad_first_reg   <= 1'b0;
            len_ok_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= init_h(3'(i));
            end
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            len_reg         <= len_next;
            round_reg       <= round_next;
            end_pending_reg <= end_pending_next;
            pad_active_reg  <= pad_active_next;
            pad_first_reg   <= pad_first_next;
            len_ok_reg      <= len_ok_next;
            m_tvalid_reg    <= m_tvalid_next;
            h_reg           <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        wv_reg     <= wv_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // round counter only moves inside a compression
    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_ROUND |-> round_reg == 6'd0)
        else $error("round counter nonzero outside compression");

    // the digest is only loaded after the final block leaves an empty buffer
    a_done_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> fill_reg == 6'd0 && pad_active_reg && len_ok_reg)
        else $error("digest stage reached with a partial block");

    // a new digest only appears out of the digest stage
    a_digest_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("digest valid raised outside digest stage");

endmodule

### dv/sha256_byte_stream_hasher_tb.sv
// self-checking testbench for the sha-256 byte stream hasher, with a digest predictor
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

    // cycle budget: ~1200 words and ~40 messages with their
    // sender gaps and receiver stalls, taken several times over
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RAND_ITEMS   = 1100;  // byte and end-marker words, noise not counted
    localparam int MIN_DIGESTS  = 30;
    localparam int DRAIN_CYCLES = 40;    // block is idle once the digest is out
    localparam int DIR_N        = 18;

    localparam bit [7:0] PAD_BYTE = 8'h80;

    localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // digest in canonical order: hi holds the first 64 bits of the hash
    typedef struct packed {
        bit [63:0] hi;
        bit [63:0] midhi;
        bit [63:0] midlo;
        bit [63:0] lo;
    } digest_t;

    typedef struct packed {
        bit [7:0] data;
        bit       has_byte;
        bit       last;
        bit       known;     // digest typed in below instead of predicted
        digest_t  digest;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;  // [7:0] data_byte
    logic         s_tuser  = 1'b0;   // [0] has_byte
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;           // [63:0] digest_hi, [127:64] digest_midhi,
                                     // [191:128] digest_midlo, [255:192] digest_lo

    // directed words: empty message, "abc" with its byte on the last word,
    // ignored words, extreme bytes, an empty end marker after bytes
    dir_row_t dir_tab [DIR_N] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1,
          256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1,
          256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hfe, 1'b0, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'haa, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h55, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    // predictor state
    bit [31:0] hash_words [8];
    bit [7:0]  block_bytes [64];
    bit [5:0]  fill_count;
    bit [60:0] byte_total;

    digest_t   digest_q [$];
    int        errors       = 0;
    int        digests_sent = 0;
    int        burst_left   = 0;
    int        cycle_count  = 0;
    digest_t   want;
    digest_t   got;

    rx_mode_t  rx_mode = RX_OPEN;
    bit [31:0] rx_pat  = '1;
    bit [4:0]  rx_ptr  = '0;
    int        rx_left = 0;

    sha256_byte_stream_hasher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        int i;
        for (i = 0; i < 8; i++) hash_words[i] = IV_WORDS[i];
        fill_count = '0;
        byte_total = '0;
    endfunction

    // one 64-round compression of block_bytes into hash_words
    function automatic void compress_block_bytes();
        bit [31:0] w [64];
        bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
        for (j = 16; j < 64; j++)
            w[j] = w[j-16] + w[j-7]
                 + (ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3))
                 + (ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10));
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (j = 0; j < 64; j++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[j] + w[j];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    // absorb one accepted word; returns 1 with the digest when the message ends
    function automatic bit absorb_word(input bit [7:0] data, input bit has_byte,
                                       input bit last, output digest_t dg);
        bit [63:0] bit_len;
        int i;
        dg = '0;
        if (has_byte) begin
            block_bytes[fill_count] = data;
            fill_count++;
            byte_total++;
            if (fill_count == 0) compress_block_bytes();
        end
        if (!last) return 1'b0;
        // padding: marker byte, zeros, then the bit length, maybe spilling to a second block
        block_bytes[fill_count] = PAD_BYTE;
        for (i = int'(fill_count) + 1; i < 64; i++) block_bytes[i] = 8'h00;
        if (fill_count > 55) begin
            compress_block_bytes();
            for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        end
        bit_len = {byte_total, 3'b000};
        for (i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
        compress_block_bytes();
        dg.hi    = {hash_words[0], hash_words[1]};
        dg.midhi = {hash_words[2], hash_words[3]};
        dg.midlo = {hash_words[4], hash_words[5]};
        dg.lo    = {hash_words[6], hash_words[7]};
        restart_message();
        return 1'b1;
    endfunction

    // send one word, bursts of random length separated by random gaps
    task automatic send_word(input bit [7:0] data, input bit has_byte, input bit last,
                             input bit known, input digest_t typed);
        int gap;
        digest_t dg;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            burst_left = int'($urandom_range(1, 48));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (absorb_word(data, has_byte, last, dg)) begin
            digest_q.push_back(known ? typed : dg);
            digests_sent++;
        end
    endtask

    // hold the sender off until every pending digest has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (digest_q.size() != 0);
    endtask

    // receiver: open stretches, random patterns and sparse acceptance
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_pat  <= $urandom;
            rx_left <= int'($urandom_range(20, 300));
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_PATTERN: m_tready <= rx_pat[rx_ptr];
            default:    m_tready <= (rx_ptr[3:0] == 4'd0);
        endcase
        rx_ptr <= rx_ptr + 1'b1;
    end

    // digest checker, oldest expectation first
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[63:0], m_tdata[127:64], m_tdata[191:128], m_tdata[255:192]};
            if (digest_q.size() == 0) begin
                $error("unexpected digest %h", got);
                errors++;
            end else begin
                want = digest_q.pop_front();
                if (got.hi !== want.hi) begin
                    $error("digest_hi expected %h got %h", want.hi, got.hi);
                    errors++;
                end
                if (got.midhi !== want.midhi) begin
                    $error("digest_midhi expected %h got %h", want.midhi, got.midhi);
                    errors++;
                end
                if (got.midlo !== want.midlo) begin
                    $error("digest_midlo expected %h got %h", want.midlo, got.midlo);
                    errors++;
                end
                if (got.lo !== want.lo) begin
                    $error("digest_lo expected %h got %h", want.lo, got.lo);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int r, len, k, items, msgs;
        bit sep_end;
        items = 0;
        msgs  = 0;
        restart_message();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (k = 0; k < DIR_N; k++)
            send_word(dir_tab[k].data, dir_tab[k].has_byte, dir_tab[k].last,
                      dir_tab[k].known, dir_tab[k].digest);
        wait_drained();

        // random messages: mostly short, some long, some right at the padding boundaries
        while (items < RAND_ITEMS || digests_sent < MIN_DIGESTS) begin
            r = int'($urandom_range(0, 99));
            if (r < 60)
                len = int'($urandom_range(0, 20));
            else if (r < 85)
                len = int'($urandom_range(21, 70));
            else
                len = BOUNDARY_LENS[$urandom_range(0, 7)];
            // end with a separate empty marker or with the byte on the last word
            sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++) begin
                // occasional ignored word with junk data in the middle of a message
                if ($urandom_range(0, 19) == 0)
                    send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                send_word(8'($urandom), 1'b1, !sep_end && (k == len - 1), 1'b0, '0);
                items++;
            end
            if (sep_end) begin
                send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
                items++;
            end
            msgs++;
            if (msgs % 8 == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
